/* hdl/eau_pkg.sv */
// Package for the 6502 effective address unit.
// Holds the addressing mode and result kind codes and the item structs.
// No dependencies.
package eau_pkg;

	// addressing modes as carried by the mode field
	typedef enum logic [3:0] {
		MODE_IMP = 4'd0,
		MODE_IMM = 4'd1,
		MODE_ZP  = 4'd2,
		MODE_ZPX = 4'd3,
		MODE_ZPY = 4'd4,
		MODE_REL = 4'd5,
		MODE_ABS = 4'd6,
		MODE_ABX = 4'd7,
		MODE_ABY = 4'd8,
		MODE_IND = 4'd9,
		MODE_IZX = 4'd10,
		MODE_IZY = 4'd11
	} mode_t;

	// command codes of an input item
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_DATA  = 1'b1;

	// result kinds
	typedef enum logic [1:0] {
		KIND_REQ     = 2'd0,
		KIND_DONE    = 2'd1,
		KIND_IGNORED = 2'd2
	} kind_t;

	// input item
	typedef struct packed {
		logic        cmd;
		logic [3:0]  mode;
		logic [15:0] pc_in;
		logic [7:0]  x_index;
		logic [7:0]  y_index;
		logic [7:0]  acc;
		logic [7:0]  rdata;
	} item_t;

	// result item
	typedef struct packed {
		kind_t       kind;
		logic [15:0] req_addr;
		logic [15:0] eff_addr;
		logic [15:0] rel_offset;
		logic [7:0]  implied_value;
		logic [15:0] next_pc;
		logic        page_cross;
	} result_t;

	// sequencer state
	typedef struct packed {
		logic        busy;
		mode_t       cur_mode;
		logic [1:0]  step_count;
		logic [15:0] pc;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [7:0]  lo_byte;
		logic [15:0] ptr;
	} seq_state_t;

endpackage

/* hdl/eau_in_stage.sv */
// Input register stage of the effective address unit.
// Captures one item per cycle while it has room, and holds it until the sequencer takes it.
// Depends on eau_pkg.
module eau_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  eau_pkg::item_t in_item,
	input  logic           advance,
	output logic           valid_s1,
	output eau_pkg::item_t item_s1
);
	import eau_pkg::*;

	// room when empty or when the held item moves on this cycle
	assign in_ready = !valid_s1 || advance;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

/* hdl/eau_seq.sv */
// Addressing mode sequencer of the effective address unit.
// Holds the calculation state and forms one result per item, combinationally from the held item.
// Depends on eau_pkg.
module eau_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  eau_pkg::item_t   item_s1,
	output eau_pkg::result_t res
);
	import eau_pkg::*;

	seq_state_t st_q;
	seq_state_t st_d;
	logic [15:0] pc_inc;
	logic [7:0]  d;
	logic [7:0]  add;
	logic [15:0] sum;

	assign pc_inc = st_q.pc + 16'd1;
	assign d      = item_s1.rdata;

	// index added in the final step of the indexed modes; IZX adds X to the pointer earlier
	always_comb begin
		case (st_q.cur_mode)
			MODE_ZPX, MODE_ABX: add = st_q.x;
			MODE_ZPY, MODE_ABY, MODE_IZY: add = st_q.y;
			default: add = 8'd0;
		endcase
	end

	// base from the returned high byte and stored low byte, plus index
	assign sum = {d, st_q.lo_byte} + {8'd0, add};

	// next state and result
	always_comb begin
		st_d = st_q;
		res  = '0;
		if (item_s1.cmd == CMD_START) begin
			st_d.busy       = 1'b0;
			st_d.pc         = item_s1.pc_in;
			st_d.x          = item_s1.x_index;
			st_d.y          = item_s1.y_index;
			st_d.step_count = 2'd0;
			case (mode_t'(item_s1.mode))
				MODE_IMM: begin
					st_d.pc      = item_s1.pc_in + 16'd1;
					res.kind     = KIND_DONE;
					res.eff_addr = item_s1.pc_in;
					res.next_pc  = item_s1.pc_in + 16'd1;
				end
				MODE_ZP, MODE_ZPX, MODE_ZPY, MODE_REL, MODE_ABS, MODE_ABX,
				MODE_ABY, MODE_IND, MODE_IZX, MODE_IZY: begin
					st_d.cur_mode = mode_t'(item_s1.mode);
					st_d.busy     = 1'b1;
					res.kind      = KIND_REQ;
					res.req_addr  = item_s1.pc_in;
				end
				default: begin
					// implied and unused codes finish at once
					res.kind          = KIND_DONE;
					res.implied_value = item_s1.acc;
					res.next_pc       = item_s1.pc_in;
				end
			endcase
		end else if (!st_q.busy) begin
			res.kind = KIND_IGNORED;
		end else begin
			case (st_q.cur_mode)
				MODE_ZP, MODE_ZPX, MODE_ZPY: begin
					st_d.pc      = pc_inc;
					st_d.busy    = 1'b0;
					res.kind     = KIND_DONE;
					res.eff_addr = {8'd0, d + add};
					res.next_pc  = pc_inc;
				end
				MODE_REL: begin
					st_d.pc        = pc_inc;
					st_d.busy      = 1'b0;
					res.kind       = KIND_DONE;
					res.rel_offset = {{8{d[7]}}, d};
					res.next_pc    = pc_inc;
				end
				MODE_ABS, MODE_ABX, MODE_ABY: begin
					st_d.pc = pc_inc;
					if (st_q.step_count == 2'd0) begin
						st_d.lo_byte    = d;
						st_d.step_count = 2'd1;
						res.kind        = KIND_REQ;
						res.req_addr    = pc_inc;
					end else begin
						st_d.busy      = 1'b0;
						res.kind       = KIND_DONE;
						res.eff_addr   = sum;
						res.next_pc    = pc_inc;
						res.page_cross = (sum[15:8] != d);
					end
				end
				MODE_IND: begin
					case (st_q.step_count)
						2'd0: begin
							st_d.pc         = pc_inc;
							st_d.lo_byte    = d;
							st_d.step_count = 2'd1;
							res.kind        = KIND_REQ;
							res.req_addr    = pc_inc;
						end
						2'd1: begin
							st_d.pc         = pc_inc;
							st_d.ptr        = {d, st_q.lo_byte};
							st_d.step_count = 2'd2;
							res.kind        = KIND_REQ;
							res.req_addr    = {d, st_q.lo_byte};
						end
						2'd2: begin
							// high pointer byte stays in the same page
							st_d.lo_byte    = d;
							st_d.step_count = 2'd3;
							res.kind        = KIND_REQ;
							res.req_addr    = {st_q.ptr[15:8], st_q.ptr[7:0] + 8'd1};
						end
						default: begin
							st_d.busy    = 1'b0;
							res.kind     = KIND_DONE;
							res.eff_addr = {d, st_q.lo_byte};
							res.next_pc  = st_q.pc;
						end
					endcase
				end
				MODE_IZX, MODE_IZY: begin
					case (st_q.step_count)
						2'd0: begin
							st_d.pc         = pc_inc;
							st_d.step_count = 2'd1;
							if (st_q.cur_mode == MODE_IZX) begin
								st_d.ptr = {8'd0, d + st_q.x};
							end else begin
								st_d.ptr = {8'd0, d};
							end
							res.kind     = KIND_REQ;
							res.req_addr = st_d.ptr;
						end
						2'd1: begin
							// pointer high byte wraps within page zero
							st_d.lo_byte    = d;
							st_d.step_count = 2'd2;
							res.kind        = KIND_REQ;
							res.req_addr    = {8'd0, st_q.ptr[7:0] + 8'd1};
						end
						default: begin
							st_d.busy      = 1'b0;
							res.kind       = KIND_DONE;
							res.eff_addr   = sum;
							res.next_pc    = st_q.pc;
							res.page_cross = (sum[15:8] != d);
						end
					endcase
				end
				default: begin
					st_d.busy = 1'b0;
					res.kind  = KIND_IGNORED;
				end
			endcase
		end
	end

	// state register, updated as each item moves to the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{busy: 1'b0, cur_mode: MODE_IMP, default: '0};
		end else if (advance) begin
			st_q <= st_d;
		end
	end

endmodule

/* hdl/eau_out_stage.sv */
// Output register stage of the effective address unit.
// Holds one result item until the receiver takes it.
// Depends on eau_pkg.
module eau_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             res_valid,
	output logic             res_ready,
	input  eau_pkg::result_t res_d,
	output logic             out_valid,
	input  logic             out_ready,
	output eau_pkg::result_t res_q
);
	import eau_pkg::*;

	// room when empty or when the held item leaves this cycle
	assign res_ready = !out_valid || out_ready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (res_ready) begin
			out_valid <= res_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			res_q <= res_d;
		end
	end

endmodule

/* hdl/cpu6502_effective_address_unit.sv */
// Top level of the 6502 effective address unit.
// Instantiates eau_in_stage, eau_seq and eau_out_stage; depends on eau_pkg.
//
// Usage:
//  - Input channel (in_valid/in_ready): a start item (cmd 0) gives mode, pc_in,
//    x_index, y_index and acc; a data item (cmd 1) returns rdata for the last
//    bus request.
//  - Output channel (out_valid/out_ready): exactly one result item per input
//    item: a bus read request (kind 0), a finished calculation (kind 1) or a
//    data item ignored while idle (kind 2).
//  - Result path: an accepted item is held in the input register, then the
//    sequencer writes its result into the output register.
//  - Throughput: one item per cycle while the receiver takes results; the sequencer
//    state is read and written as each item moves between input and output registers.
//  - A start while a calculation runs abandons it.
//  - Reset clears both stage valid flags and the sequencer state to idle.
//  - When the receiver stalls, the result stays in the output register, one
//    more item is held in the input register, then in_ready drops.
module cpu6502_effective_address_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [3:0]  mode,
	input  logic [15:0] pc_in,
	input  logic [7:0]  x_index,
	input  logic [7:0]  y_index,
	input  logic [7:0]  acc,
	input  logic [7:0]  rdata,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [15:0] req_addr,
	output logic [15:0] eff_addr,
	output logic [15:0] rel_offset,
	output logic [7:0]  implied_value,
	output logic [15:0] next_pc,
	output logic        page_cross
);
	import eau_pkg::*;

	item_t   in_item;
	item_t   item_s1;
	logic    valid_s1;
	logic    res_ready;
	logic    advance;
	result_t res_d;
	result_t res_q;

	// gather input fields
	assign in_item = '{cmd: cmd, mode: mode, pc_in: pc_in, x_index: x_index,
		y_index: y_index, acc: acc, rdata: rdata};

	// item moves from input register to output register
	assign advance = valid_s1 && res_ready;

	eau_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	eau_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item_s1 (item_s1),
		.res     (res_d)
	);

	eau_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (valid_s1),
		.res_ready (res_ready),
		.res_d     (res_d),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_q     (res_q)
	);

	// result fields
	assign kind          = res_q.kind;
	assign req_addr      = res_q.req_addr;
	assign eff_addr      = res_q.eff_addr;
	assign rel_offset    = res_q.rel_offset;
	assign implied_value = res_q.implied_value;
	assign next_pc       = res_q.next_pc;
	assign page_cross    = res_q.page_cross;

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for cpu6502_effective_address_unit: directed and random
// start/read-data items, an in-bench address predictor and in-order result checks.
// Depends on eau_pkg and the RTL under hdl.
module tb;
	import eau_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 60;
	localparam int ITEMS_PER_PHASE = 360;
	localparam logic [3:0] MODE_UNUSED_MAX = 4'd15;
	localparam logic [3:0] MODE_UNUSED_MIN = 4'd12;

	logic clk;
	logic arst_n = 1'b0;

	// block ports
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        cmd;
	logic [3:0]  mode;
	logic [15:0] pc_in;
	logic [7:0]  x_index;
	logic [7:0]  y_index;
	logic [7:0]  acc;
	logic [7:0]  rdata;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [15:0] req_addr;
	logic [15:0] eff_addr;
	logic [15:0] rel_offset;
	logic [7:0]  implied_value;
	logic [15:0] next_pc;
	logic        page_cross;

	// item on the input port
	item_t offered = '0;
	assign cmd     = offered.cmd;
	assign mode    = offered.mode;
	assign pc_in   = offered.pc_in;
	assign x_index = offered.x_index;
	assign y_index = offered.y_index;
	assign acc     = offered.acc;
	assign rdata   = offered.rdata;

	item_t   pending_items[$];
	result_t expected_results[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_requests = 0;
	int error_count = 0;
	int result_count = 0;
	int quiet_cycles = 0;

	// predicted sequencer state
	logic        seq_busy = 1'b0;
	mode_t       seq_mode = MODE_IMP;
	logic [1:0]  seq_step = 2'd0;
	logic [15:0] seq_pc = 16'h0000;
	logic [7:0]  seq_x = 8'h00;
	logic [7:0]  seq_y = 8'h00;
	logic [7:0]  seq_lo = 8'h00;
	logic [15:0] seq_ptr = 16'h0000;

	cpu6502_effective_address_unit dut (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// address prediction for one accepted item, advancing the predicted state
	function automatic result_t predict_address(input item_t it);
		result_t r;
		logic [7:0] add;
		logic [7:0] zp;
		logic [15:0] ea;
		r = '0;
		add = 8'h00;
		if (it.cmd == CMD_START) begin
			seq_busy = 1'b0;
			seq_pc = it.pc_in;
			seq_x = it.x_index;
			seq_y = it.y_index;
			seq_step = 2'd0;
			if (it.mode == MODE_IMP || it.mode > MODE_IZY) begin
				r.kind = KIND_DONE;
				r.implied_value = it.acc;
			end else if (it.mode == MODE_IMM) begin
				r.kind = KIND_DONE;
				r.eff_addr = seq_pc;
				seq_pc = seq_pc + 16'd1;
			end else begin
				seq_mode = mode_t'(it.mode);
				seq_busy = 1'b1;
				r.kind = KIND_REQ;
				r.req_addr = seq_pc;
			end
		end else if (!seq_busy) begin
			r.kind = KIND_IGNORED;
		end else begin
			case (seq_mode)
				MODE_ZP, MODE_ZPX, MODE_ZPY: begin
					if (seq_mode == MODE_ZPX)
						add = seq_x;
					else if (seq_mode == MODE_ZPY)
						add = seq_y;
					zp = it.rdata + add;
					seq_pc = seq_pc + 16'd1;
					r.kind = KIND_DONE;
					r.eff_addr = {8'h00, zp};
				end
				MODE_REL: begin
					seq_pc = seq_pc + 16'd1;
					r.kind = KIND_DONE;
					r.rel_offset = {{8{it.rdata[7]}}, it.rdata};
				end
				MODE_ABS, MODE_ABX, MODE_ABY: begin
					seq_pc = seq_pc + 16'd1;
					if (seq_step == 2'd0) begin
						seq_lo = it.rdata;
						seq_step = 2'd1;
						r.kind = KIND_REQ;
						r.req_addr = seq_pc;
					end else begin
						if (seq_mode == MODE_ABX)
							add = seq_x;
						else if (seq_mode == MODE_ABY)
							add = seq_y;
						ea = {it.rdata, seq_lo} + {8'h00, add};
						r.kind = KIND_DONE;
						r.eff_addr = ea;
						r.page_cross = (ea[15:8] != it.rdata);
					end
				end
				MODE_IND: begin
					// high pointer byte stays in the pointer's page
					case (seq_step)
						2'd0: begin
							seq_pc = seq_pc + 16'd1;
							seq_lo = it.rdata;
							seq_step = 2'd1;
							r.kind = KIND_REQ;
							r.req_addr = seq_pc;
						end
						2'd1: begin
							seq_pc = seq_pc + 16'd1;
							seq_ptr = {it.rdata, seq_lo};
							seq_step = 2'd2;
							r.kind = KIND_REQ;
							r.req_addr = seq_ptr;
						end
						2'd2: begin
							seq_lo = it.rdata;
							seq_step = 2'd3;
							r.kind = KIND_REQ;
							r.req_addr = {seq_ptr[15:8], seq_ptr[7:0] + 8'd1};
						end
						default: begin
							r.kind = KIND_DONE;
							r.eff_addr = {it.rdata, seq_lo};
						end
					endcase
				end
				MODE_IZX, MODE_IZY: begin
					// pointer lives in page zero and wraps there
					if (seq_step == 2'd0) begin
						if (seq_mode == MODE_IZX)
							add = seq_x;
						zp = it.rdata + add;
						seq_pc = seq_pc + 16'd1;
						seq_ptr = {8'h00, zp};
						seq_step = 2'd1;
						r.kind = KIND_REQ;
						r.req_addr = seq_ptr;
					end else if (seq_step == 2'd1) begin
						seq_lo = it.rdata;
						seq_step = 2'd2;
						r.kind = KIND_REQ;
						r.req_addr = {8'h00, seq_ptr[7:0] + 8'd1};
					end else begin
						if (seq_mode == MODE_IZY)
							add = seq_y;
						ea = {it.rdata, seq_lo} + {8'h00, add};
						r.kind = KIND_DONE;
						r.eff_addr = ea;
						r.page_cross = (ea[15:8] != it.rdata);
					end
				end
				default: begin
					seq_busy = 1'b0;
					r.kind = KIND_IGNORED;
				end
			endcase
		end
		// a finished calculation reports the pc and frees the sequencer
		if (r.kind == KIND_DONE) begin
			r.next_pc = seq_pc;
			seq_busy = 1'b0;
		end
		return r;
	endfunction

	// number of bus reads each mode needs before it finishes
	function automatic int operand_reads(input logic [3:0] m);
		case (m)
			MODE_ZP, MODE_ZPX, MODE_ZPY, MODE_REL: return 1;
			MODE_ABS, MODE_ABX, MODE_ABY: return 2;
			MODE_IZX, MODE_IZY: return 3;
			MODE_IND: return 4;
			default: return 0;
		endcase
	endfunction

	// bytes with the boundary values weighted up
	function automatic logic [7:0] rand_byte();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h80;
			3: return 8'h7F;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] rand_pc();
		if ($urandom_range(7) == 0)
			return 16'($urandom_range(16'hFFFF, 16'hFFFC));
		return 16'($urandom);
	endfunction

	task automatic push_start(input logic [3:0] m, input logic [15:0] pc,
			input logic [7:0] x, input logic [7:0] y, input logic [7:0] a);
		item_t it;
		it.cmd = CMD_START;
		it.mode = m;
		it.pc_in = pc;
		it.x_index = x;
		it.y_index = y;
		it.acc = a;
		it.rdata = 8'($urandom);
		pending_items.push_back(it);
	endtask

	// data item: only rdata matters, the rest is random
	task automatic push_data(input logic [7:0] d);
		item_t it;
		it.cmd = CMD_DATA;
		it.mode = 4'($urandom);
		it.pc_in = 16'($urandom);
		it.x_index = 8'($urandom);
		it.y_index = 8'($urandom);
		it.acc = 8'($urandom);
		it.rdata = d;
		pending_items.push_back(it);
	endtask

	task automatic push_sequence(input logic [3:0] m, input int reads);
		push_start(m, rand_pc(), rand_byte(), rand_byte(), rand_byte());
		repeat (reads) push_data(rand_byte());
	endtask

	task automatic push_random_items();
		int counted;
		int pick;
		int reads;
		logic [3:0] m;
		counted = 0;
		while (counted < ITEMS_PER_PHASE) begin
			pick = $urandom_range(99);
			if (pick < 80) begin
				// complete calculation
				m = 4'($urandom_range(MODE_IZY));
				reads = operand_reads(m);
				push_sequence(m, reads);
				counted += 1 + reads;
			end else if (pick < 88) begin
				// calculation cut short by the next start
				m = 4'($urandom_range(MODE_IZY, MODE_ZP));
				reads = $urandom_range(operand_reads(m) - 1);
				push_sequence(m, reads);
				counted += 1 + reads;
			end else if (pick < 94) begin
				push_data(rand_byte());
				counted += 1;
			end else begin
				push_sequence(4'($urandom_range(MODE_UNUSED_MAX, MODE_UNUSED_MIN)), 0);
				counted += 1;
			end
		end
	endtask

	// sender pause until the block has answered everything
	task automatic wait_drained();
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic report_fault(input string msg);
		$display("result %0d: %s", result_count, msg);
		error_count++;
	endtask

	task automatic compare_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_fault($sformatf("%s got %h expected %h", name, got, want));
	endtask

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			offered <= '0;
		end else begin
			if (in_valid && in_ready)
				expected_results.push_back(predict_address(offered));
			if (!in_valid || in_ready) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					offered <= pending_items.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stalls
	int hold_left = 0;
	int holds_served = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_fault($sformatf("unexpected item of kind %0d", kind));
				end else begin
					result_t want;
					want = expected_results.pop_front();
					compare_field("kind", 16'(kind), 16'(want.kind));
					compare_field("req_addr", req_addr, want.req_addr);
					compare_field("eff_addr", eff_addr, want.eff_addr);
					compare_field("rel_offset", rel_offset, want.rel_offset);
					compare_field("implied_value", 16'(implied_value), 16'(want.implied_value));
					compare_field("next_pc", next_pc, want.next_pc);
					compare_field("page_cross", 16'(page_cross), 16'(want.page_cross));
				end
				result_count++;
			end
			if (holds_served != hold_requests) begin
				holds_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("cpu6502_effective_address_unit regression: fail");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// stimulus and run control
	initial begin
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// phase one: sender idles a little, receiver a lot
		send_idle_pct = 18;
		recv_idle_pct = 83;
		push_start(MODE_IMP, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
		push_start(MODE_UNUSED_MAX, 16'h0000, 8'h00, 8'h00, 8'h00);
		push_data(8'hA5);
		push_start(MODE_IMM, 16'hFFFF, 8'h00, 8'h00, 8'h00);
		push_start(MODE_ZPX, 16'h1234, 8'hFF, 8'h00, 8'h00);
		push_data(8'h80);
		push_start(MODE_REL, 16'h0200, 8'h00, 8'h00, 8'h00);
		push_data(8'h80);
		// absolute fetch abandoned by the indirect jump start
		push_start(MODE_ABS, 16'hFFFF, 8'h00, 8'h00, 8'h00);
		push_data(8'h34);
		push_start(MODE_IND, 16'h0300, 8'h00, 8'h00, 8'h00);
		push_data(8'hFF);
		push_data(8'h12);
		push_data(8'h00);
		push_data(8'h40);
		push_start(MODE_ABX, 16'h0400, 8'h01, 8'h00, 8'h00);
		push_data(8'hFF);
		push_data(8'h20);
		push_start(MODE_ABY, 16'hFFFE, 8'h00, 8'hFF, 8'h00);
		push_data(8'hFF);
		push_data(8'hFF);
		push_start(MODE_IZX, 16'h0500, 8'h01, 8'h00, 8'h00);
		push_data(8'hFE);
		push_data(8'h00);
		push_data(8'h90);
		push_start(MODE_IZY, 16'h0600, 8'h00, 8'h80, 8'h00);
		push_data(8'h10);
		push_data(8'hC0);
		push_data(8'h12);
		push_random_items();
		wait_drained();

		// phase two: the other way round
		send_idle_pct = 83;
		recv_idle_pct = 18;
		push_random_items();
		wait_drained();

		// phase three: no idling, one long receiver hold to back up the input
		send_idle_pct = 0;
		recv_idle_pct = 0;
		push_random_items();
		hold_requests++;
		wait_drained();

		if (error_count == 0)
			$display("cpu6502_effective_address_unit regression: pass");
		else
			$display("cpu6502_effective_address_unit regression: fail");
		$finish;
	end

endmodule
